### design/rvalu_pkg.sv
// Shared types, codes and constants for the RV32I integer ALU execute block.
package rvalu_pkg;

  localparam int unsigned Xlen     = 32;
  localparam int unsigned NumRegs  = 32;
  localparam int unsigned RegAddrW = 5;

  typedef logic [Xlen-1:0]     word_t;
  typedef logic [RegAddrW-1:0] reg_addr_t;

  typedef enum logic [1:0] {
    ModeExec = 2'd0,
    ModeLoad = 2'd1,
    ModeRead = 2'd2,
    ModeNop  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StIllegal  = 2'd1,
    StUnimpl   = 2'd2,
    StNonexist = 2'd3
  } status_e;

  // Major opcodes
  localparam logic [6:0] OpcOp      = 7'h33;
  localparam logic [6:0] OpcOpImm   = 7'h13;
  localparam logic [6:0] OpcLoad    = 7'h03;
  localparam logic [6:0] OpcMiscMem = 7'h0F;
  localparam logic [6:0] OpcJalr    = 7'h67;
  localparam logic [6:0] OpcSystem  = 7'h73;
  localparam logic [6:0] OpcStore   = 7'h23;
  localparam logic [6:0] OpcBranch  = 7'h63;
  localparam logic [6:0] OpcAuipc   = 7'h17;
  localparam logic [6:0] OpcLui     = 7'h37;
  localparam logic [6:0] OpcJal     = 7'h6F;

  localparam logic [6:0] Funct7Zero = 7'h00;
  localparam logic [6:0] Funct7Alt  = 7'h20;

  // funct3 codes
  localparam logic [2:0] F3AddSub = 3'd0;
  localparam logic [2:0] F3Sll    = 3'd1;
  localparam logic [2:0] F3Slt    = 3'd2;
  localparam logic [2:0] F3Sltu   = 3'd3;
  localparam logic [2:0] F3Xor    = 3'd4;
  localparam logic [2:0] F3Srl    = 3'd5;
  localparam logic [2:0] F3Or     = 3'd6;
  localparam logic [2:0] F3And    = 3'd7;

  typedef struct packed {
    status_e   status;
    logic      wrote;
    reg_addr_t dest_index;
    word_t     dest_value;
  } result_t;

  typedef struct packed {
    logic      en;
    reg_addr_t addr;
    word_t     data;
  } rf_write_t;

endpackage

### design/rvalu_regfile.sv
// Register file: 32 x 32 memory with reset valid bits, two registered read ports and bypass.
module rvalu_regfile (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  rvalu_pkg::reg_addr_t  raddr_a_i,
  input  rvalu_pkg::reg_addr_t  raddr_b_i,
  input  rvalu_pkg::rf_write_t  wr_i,
  output rvalu_pkg::word_t      rdata_a_o,
  output rvalu_pkg::word_t      rdata_b_o
);

  rvalu_pkg::word_t                  mem_q [rvalu_pkg::NumRegs];
  logic [rvalu_pkg::NumRegs-1:0]     valid_q;
  rvalu_pkg::word_t                  rdata_a_q;
  rvalu_pkg::word_t                  rdata_b_q;
  logic                              wr_ok;

  // x0 is never stored, so its valid bit stays low and it reads zero
  assign wr_ok = wr_i.en && (wr_i.addr != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_ok) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Forward a write landing on the same edge as the read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_ok && (wr_i.addr == raddr_a_i)) begin
        rdata_a_q <= wr_i.data;
      end else begin
        rdata_a_q <= valid_q[raddr_a_i] ? mem_q[raddr_a_i] : '0;
      end
      if (wr_ok && (wr_i.addr == raddr_b_i)) begin
        rdata_b_q <= wr_i.data;
      end else begin
        rdata_b_q <= valid_q[raddr_b_i] ? mem_q[raddr_b_i] : '0;
      end
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### design/rvalu_exec.sv
// Decode and ALU: turns one request plus operand data into a result and a register write.
module rvalu_exec (
  input  rvalu_pkg::mode_e      mode_i,
  input  rvalu_pkg::word_t      instruction_i,
  input  rvalu_pkg::reg_addr_t  reg_index_i,
  input  rvalu_pkg::word_t      reg_value_i,
  input  rvalu_pkg::word_t      rs1_data_i,
  input  rvalu_pkg::word_t      rs2_data_i,
  output rvalu_pkg::result_t    result_o,
  output rvalu_pkg::rf_write_t  wr_o
);

  function automatic rvalu_pkg::word_t alu(logic [2:0] f3, logic alt,
                                           rvalu_pkg::word_t a, rvalu_pkg::word_t b);
    rvalu_pkg::word_t y;
    case (f3)
      rvalu_pkg::F3AddSub: y = alt ? (a - b) : (a + b);
      rvalu_pkg::F3Sll:    y = a << b[4:0];
      rvalu_pkg::F3Slt:    y = {31'd0, ($signed(a) < $signed(b))};
      rvalu_pkg::F3Sltu:   y = {31'd0, (a < b)};
      rvalu_pkg::F3Xor:    y = a ^ b;
      rvalu_pkg::F3Srl:    y = alt ? rvalu_pkg::word_t'($signed(a) >>> b[4:0]) : (a >> b[4:0]);
      rvalu_pkg::F3Or:     y = a | b;
      default:             y = a & b;
    endcase
    return y;
  endfunction

  logic [6:0]           opc;
  logic [6:0]           f7;
  logic [2:0]           f3;
  rvalu_pkg::reg_addr_t rd;
  rvalu_pkg::word_t     imm;

  assign opc = instruction_i[6:0];
  assign rd  = instruction_i[11:7];
  assign f3  = instruction_i[14:12];
  assign f7  = instruction_i[31:25];
  assign imm = {{20{instruction_i[31]}}, instruction_i[31:20]};

  always_comb begin
    result_o.status     = rvalu_pkg::StOk;
    result_o.wrote      = 1'b0;
    result_o.dest_index = reg_index_i;
    result_o.dest_value = '0;
    wr_o.en   = 1'b0;
    wr_o.addr = reg_index_i;
    wr_o.data = reg_value_i;

    case (mode_i)
      rvalu_pkg::ModeExec: begin
        result_o.dest_index = rd;
        case (opc)
          rvalu_pkg::OpcOp: begin
            if ((f7 == rvalu_pkg::Funct7Zero) ||
                ((f7 == rvalu_pkg::Funct7Alt) &&
                 (f3 inside {rvalu_pkg::F3AddSub, rvalu_pkg::F3Srl}))) begin
              result_o.dest_value = alu(f3, f7 == rvalu_pkg::Funct7Alt, rs1_data_i, rs2_data_i);
            end else begin
              result_o.status = rvalu_pkg::StIllegal;
            end
          end
          rvalu_pkg::OpcOpImm: begin
            if (((f3 == rvalu_pkg::F3Sll) && (f7 != rvalu_pkg::Funct7Zero)) ||
                ((f3 == rvalu_pkg::F3Srl) &&
                 !(f7 inside {rvalu_pkg::Funct7Zero, rvalu_pkg::Funct7Alt}))) begin
              result_o.status = rvalu_pkg::StIllegal;
            end else begin
              result_o.dest_value = alu(f3, (f3 == rvalu_pkg::F3Srl) &&
                                            (f7 == rvalu_pkg::Funct7Alt), rs1_data_i, imm);
            end
          end
          rvalu_pkg::OpcLoad, rvalu_pkg::OpcMiscMem, rvalu_pkg::OpcJalr,
          rvalu_pkg::OpcSystem, rvalu_pkg::OpcStore, rvalu_pkg::OpcBranch,
          rvalu_pkg::OpcAuipc, rvalu_pkg::OpcLui, rvalu_pkg::OpcJal: begin
            result_o.status = rvalu_pkg::StUnimpl;
          end
          default: begin
            result_o.status = rvalu_pkg::StNonexist;
          end
        endcase
        wr_o.addr = rd;
        wr_o.data = result_o.dest_value;
        wr_o.en   = (result_o.status == rvalu_pkg::StOk) && (rd != '0);
        result_o.wrote = wr_o.en;
      end
      rvalu_pkg::ModeLoad: begin
        wr_o.en             = (reg_index_i != '0);
        result_o.wrote      = wr_o.en;
        result_o.dest_value = wr_o.en ? reg_value_i : '0;
      end
      rvalu_pkg::ModeRead: begin
        result_o.dest_value = rs1_data_i;
      end
      default: begin
        result_o.dest_value = '0;
      end
    endcase
  end

endmodule

### design/rv32i_integer_alu_execute.sv
// Throughput: one request per cycle while the result side is ready. A request
// and its register file read are registered at accept; the single ALU pass in
// the execute stage loads the result register on advance, with write bypass.
// Reset clears control state and marks every register as zero through per-entry
// valid bits, so requests are taken right after reset with no clearing pass.
// Top level of the RV32I integer ALU execute block.
module rv32i_integer_alu_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] instruction_i,
  input  logic [4:0]  reg_index_i,
  input  logic [31:0] reg_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        wrote_register_o,
  output logic [4:0]  dest_index_o,
  output logic [31:0] dest_value_o
);

  logic                  s1_valid_q;
  rvalu_pkg::mode_e      s1_mode_q;
  rvalu_pkg::word_t      s1_instr_q;
  rvalu_pkg::reg_addr_t  s1_idx_q;
  rvalu_pkg::word_t      s1_val_q;
  logic                  out_valid_q;
  rvalu_pkg::result_t    out_res_q;

  logic                  in_fire;
  logic                  s1_adv;
  rvalu_pkg::reg_addr_t  raddr_a;
  rvalu_pkg::word_t      rs1_data;
  rvalu_pkg::word_t      rs2_data;
  rvalu_pkg::result_t    exec_res;
  rvalu_pkg::rf_write_t  rf_wr;
  rvalu_pkg::rf_write_t  rf_wr_gated;

  // Advance the execute stage whenever the result register is free or draining
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  assign raddr_a = (rvalu_pkg::mode_e'(mode_i) == rvalu_pkg::ModeExec) ?
                   instruction_i[19:15] : reg_index_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q  <= rvalu_pkg::mode_e'(mode_i);
      s1_instr_q <= instruction_i;
      s1_idx_q   <= reg_index_i;
      s1_val_q   <= reg_value_i;
    end
  end

  // Commit the register write only when the request leaves the execute stage
  always_comb begin
    rf_wr_gated    = rf_wr;
    rf_wr_gated.en = rf_wr.en && s1_adv;
  end

  rvalu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .raddr_a_i (raddr_a),
    .raddr_b_i (instruction_i[24:20]),
    .wr_i      (rf_wr_gated),
    .rdata_a_o (rs1_data),
    .rdata_b_o (rs2_data)
  );

  rvalu_exec u_exec (
    .mode_i        (s1_mode_q),
    .instruction_i (s1_instr_q),
    .reg_index_i   (s1_idx_q),
    .reg_value_i   (s1_val_q),
    .rs1_data_i    (rs1_data),
    .rs2_data_i    (rs2_data),
    .result_o      (exec_res),
    .wr_o          (rf_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q <= exec_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_res_q.status;
  assign wrote_register_o = out_res_q.wrote;
  assign dest_index_o     = out_res_q.dest_index;
  assign dest_value_o     = out_res_q.dest_value;

`ifndef SYNTHESIS
  a_ready_when_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled while result register is empty");

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr_gated.en |-> (rf_wr_gated.addr != '0))
    else $error("register write targets x0");

  a_write_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr_gated.en |-> (s1_valid_q && exec_res.wrote))
    else $error("register write without a committing request");

  a_wrote_implies_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.wrote |-> (out_res_q.status == rvalu_pkg::StOk))
    else $error("write reported with non-ok status");

  a_adv_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced request did not reach the result register");
`endif

endmodule

### test/tb_rv32i_integer_alu_execute.sv
// Self-checking testbench for the RV32I integer ALU execute block.
module tb_rv32i_integer_alu_execute;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned RandPerPhase = 170;
  localparam logic [6:0] OpcUndef = 7'h7F;

  typedef struct {
    rvalu_pkg::mode_e     mode;
    rvalu_pkg::word_t     instr;
    rvalu_pkg::reg_addr_t idx;
    rvalu_pkg::word_t     value;
    logic                 known;
    rvalu_pkg::result_t   want;
  } alu_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [31:0] instruction_i = '0;
  logic [4:0]  reg_index_i = '0;
  logic [31:0] reg_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic        wrote_register_o;
  logic [4:0]  dest_index_o;
  logic [31:0] dest_value_o;

  rvalu_pkg::word_t   shadow_rf [rvalu_pkg::NumRegs] = '{default: '0};
  rvalu_pkg::result_t pending_results [$];
  logic               drv_known = 1'b0;
  rvalu_pkg::result_t drv_want = '0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  logic [6:0]  unimpl_opcodes [0:8] = '{rvalu_pkg::OpcLoad, rvalu_pkg::OpcMiscMem,
                                        rvalu_pkg::OpcJalr, rvalu_pkg::OpcSystem,
                                        rvalu_pkg::OpcStore, rvalu_pkg::OpcBranch,
                                        rvalu_pkg::OpcAuipc, rvalu_pkg::OpcLui,
                                        rvalu_pkg::OpcJal};

  rv32i_integer_alu_execute u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .instruction_i    (instruction_i),
    .reg_index_i      (reg_index_i),
    .reg_value_i      (reg_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .wrote_register_o (wrote_register_o),
    .dest_index_o     (dest_index_o),
    .dest_value_o     (dest_value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic rvalu_pkg::word_t r_op(logic [6:0] f7, logic [2:0] f3,
                                            rvalu_pkg::reg_addr_t rd,
                                            rvalu_pkg::reg_addr_t rs1,
                                            rvalu_pkg::reg_addr_t rs2);
    return {f7, rs2, rs1, f3, rd, rvalu_pkg::OpcOp};
  endfunction

  function automatic rvalu_pkg::word_t i_op(logic [11:0] imm, logic [2:0] f3,
                                            rvalu_pkg::reg_addr_t rd,
                                            rvalu_pkg::reg_addr_t rs1);
    return {imm, rs1, f3, rd, rvalu_pkg::OpcOpImm};
  endfunction

  function automatic alu_item_t exec_row(rvalu_pkg::word_t ins);
    alu_item_t it;
    it.mode  = rvalu_pkg::ModeExec;
    it.instr = ins;
    it.idx   = '0;
    it.value = '0;
    it.known = 1'b0;
    it.want  = '0;
    return it;
  endfunction

  function automatic alu_item_t known_row(rvalu_pkg::mode_e m, rvalu_pkg::word_t ins,
                                          rvalu_pkg::reg_addr_t ix, rvalu_pkg::word_t v,
                                          rvalu_pkg::status_e st, logic wr,
                                          rvalu_pkg::reg_addr_t dix, rvalu_pkg::word_t dv);
    alu_item_t it;
    it.mode  = m;
    it.instr = ins;
    it.idx   = ix;
    it.value = v;
    it.known = 1'b1;
    it.want.status     = st;
    it.want.wrote      = wr;
    it.want.dest_index = dix;
    it.want.dest_value = dv;
    return it;
  endfunction

  function automatic rvalu_pkg::word_t alu_op(logic [2:0] f3, logic alt,
                                              rvalu_pkg::word_t a, rvalu_pkg::word_t b);
    case (f3)
      rvalu_pkg::F3AddSub: return alt ? a - b : a + b;
      rvalu_pkg::F3Sll:    return a << b[4:0];
      rvalu_pkg::F3Slt:    return {31'd0, ($signed(a) < $signed(b))};
      rvalu_pkg::F3Sltu:   return {31'd0, (a < b)};
      rvalu_pkg::F3Xor:    return a ^ b;
      rvalu_pkg::F3Srl: begin
        if (alt) return rvalu_pkg::word_t'($signed(a) >>> b[4:0]);
        else return a >> b[4:0];
      end
      rvalu_pkg::F3Or:     return a | b;
      default:             return a & b;
    endcase
  endfunction

  // Advance the shadow register file by one request and return its result.
  function automatic rvalu_pkg::result_t predict_alu_result(rvalu_pkg::mode_e mode,
                                                            rvalu_pkg::word_t instr,
                                                            rvalu_pkg::reg_addr_t idx,
                                                            rvalu_pkg::word_t value);
    rvalu_pkg::result_t   r;
    logic [6:0]           opc;
    logic [6:0]           f7;
    logic [2:0]           f3;
    rvalu_pkg::reg_addr_t rd;
    rvalu_pkg::word_t     a;
    rvalu_pkg::word_t     imm;
    opc = instr[6:0];
    f7  = instr[31:25];
    f3  = instr[14:12];
    rd  = instr[11:7];
    a   = shadow_rf[instr[19:15]];
    imm = {{20{instr[31]}}, instr[31:20]};
    r.status     = rvalu_pkg::StOk;
    r.wrote      = 1'b0;
    r.dest_index = idx;
    r.dest_value = '0;
    case (mode)
      rvalu_pkg::ModeExec: begin
        r.dest_index = rd;
        case (opc)
          rvalu_pkg::OpcOp: begin
            if (f7 == rvalu_pkg::Funct7Zero || (f7 == rvalu_pkg::Funct7Alt &&
                f3 inside {rvalu_pkg::F3AddSub, rvalu_pkg::F3Srl}))
              r.dest_value = alu_op(f3, f7 == rvalu_pkg::Funct7Alt, a,
                                    shadow_rf[instr[24:20]]);
            else
              r.status = rvalu_pkg::StIllegal;
          end
          rvalu_pkg::OpcOpImm: begin
            if ((f3 == rvalu_pkg::F3Sll && f7 != rvalu_pkg::Funct7Zero) ||
                (f3 == rvalu_pkg::F3Srl &&
                 !(f7 inside {rvalu_pkg::Funct7Zero, rvalu_pkg::Funct7Alt})))
              r.status = rvalu_pkg::StIllegal;
            else
              r.dest_value = alu_op(f3, f3 == rvalu_pkg::F3Srl && f7 == rvalu_pkg::Funct7Alt,
                                    a, imm);
          end
          rvalu_pkg::OpcLoad, rvalu_pkg::OpcMiscMem, rvalu_pkg::OpcJalr,
          rvalu_pkg::OpcSystem, rvalu_pkg::OpcStore, rvalu_pkg::OpcBranch,
          rvalu_pkg::OpcAuipc, rvalu_pkg::OpcLui,
          rvalu_pkg::OpcJal: r.status = rvalu_pkg::StUnimpl;
          default: r.status = rvalu_pkg::StNonexist;
        endcase
        if (r.status == rvalu_pkg::StOk && rd != '0) begin
          shadow_rf[rd] = r.dest_value;
          r.wrote = 1'b1;
        end
      end
      rvalu_pkg::ModeLoad: begin
        if (idx != '0) begin
          shadow_rf[idx] = value;
          r.wrote = 1'b1;
        end
        r.dest_value = shadow_rf[idx];
      end
      rvalu_pkg::ModeRead: r.dest_value = shadow_rf[idx];
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %0s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(alu_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= it.mode;
    instruction_i <= it.instr;
    reg_index_i   <= it.idx;
    reg_value_i   <= it.value;
    drv_known = it.known;
    drv_want  = it.want;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_ready_i  <= 1'b0;
      hold_left    <= HoldCycles;
      holds_served <= holds_served + 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    rvalu_pkg::result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", dest_value_o, '0);
      end else begin
        exp_res = pending_results.pop_front();
        if (status_o !== exp_res.status)
          report_mismatch("status", 32'(status_o), 32'(exp_res.status));
        if (wrote_register_o !== exp_res.wrote)
          report_mismatch("wrote_register", 32'(wrote_register_o), 32'(exp_res.wrote));
        if (dest_index_o !== exp_res.dest_index)
          report_mismatch("dest_index", 32'(dest_index_o), 32'(exp_res.dest_index));
        if (dest_value_o !== exp_res.dest_value)
          report_mismatch("dest_value", dest_value_o, exp_res.dest_value);
      end
    end
    // Run the predictor for every request so the shadow registers stay in step.
    if (rst_ni && in_valid_i && in_ready_o) begin
      exp_res = predict_alu_result(rvalu_pkg::mode_e'(mode_i), instruction_i, reg_index_i,
                                   reg_value_i);
      pending_results.push_back(drv_known ? drv_want : exp_res);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("%0t watchdog: no handshake for %0d cycles", $realtime, QuietLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    alu_item_t            rows [$];
    alu_item_t            it;
    int unsigned          idle_plan [4];
    int unsigned          stall_plan [4];
    int unsigned          kind;
    logic [2:0]           f3;
    logic [6:0]           f7;
    logic [11:0]          imm;
    rvalu_pkg::reg_addr_t rd;
    rvalu_pkg::reg_addr_t rs1;
    rvalu_pkg::reg_addr_t rs2;
    idle_plan  = '{0, 86, 0, 13};
    stall_plan = '{0, 0, 86, 13};

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    rows.push_back(known_row(rvalu_pkg::ModeRead, '0, 5'd5, '0, rvalu_pkg::StOk, 1'b0,
                             5'd5, '0));
    rows.push_back(known_row(rvalu_pkg::ModeLoad, '0, 5'd0, '1, rvalu_pkg::StOk, 1'b0,
                             5'd0, '0));
    rows.push_back(known_row(rvalu_pkg::ModeLoad, '0, 5'd1, '1, rvalu_pkg::StOk, 1'b1,
                             5'd1, '1));
    rows.push_back(known_row(rvalu_pkg::ModeLoad, '0, 5'd2, 32'h8000_0000, rvalu_pkg::StOk,
                             1'b1, 5'd2, 32'h8000_0000));
    rows.push_back(known_row(rvalu_pkg::ModeLoad, '0, 5'd31, 32'h7FFF_FFFF, rvalu_pkg::StOk,
                             1'b1, 5'd31, 32'h7FFF_FFFF));
    rows.push_back(exec_row(r_op(rvalu_pkg::Funct7Zero, rvalu_pkg::F3AddSub, 5'd3, 5'd1,
                                 5'd2)));
    rows.push_back(exec_row(r_op(rvalu_pkg::Funct7Alt, rvalu_pkg::F3AddSub, 5'd4, 5'd2,
                                 5'd1)));
    rows.push_back(exec_row(r_op(rvalu_pkg::Funct7Zero, rvalu_pkg::F3Sll, 5'd5, 5'd1, 5'd31)));
    rows.push_back(exec_row(r_op(rvalu_pkg::Funct7Zero, rvalu_pkg::F3Slt, 5'd6, 5'd2, 5'd31)));
    rows.push_back(exec_row(r_op(rvalu_pkg::Funct7Zero, rvalu_pkg::F3Sltu, 5'd7, 5'd2,
                                 5'd31)));
    rows.push_back(exec_row(r_op(rvalu_pkg::Funct7Zero, rvalu_pkg::F3Xor, 5'd8, 5'd1, 5'd31)));
    rows.push_back(exec_row(r_op(rvalu_pkg::Funct7Zero, rvalu_pkg::F3Srl, 5'd9, 5'd2, 5'd31)));
    rows.push_back(exec_row(r_op(rvalu_pkg::Funct7Alt, rvalu_pkg::F3Srl, 5'd10, 5'd2, 5'd31)));
    // destination x0: result still reported, nothing written
    rows.push_back(exec_row(r_op(rvalu_pkg::Funct7Zero, rvalu_pkg::F3Or, 5'd0, 5'd2, 5'd31)));
    rows.push_back(exec_row(r_op(rvalu_pkg::Funct7Zero, rvalu_pkg::F3And, 5'd11, 5'd1, 5'd2)));
    rows.push_back(exec_row(i_op(12'hFFF, rvalu_pkg::F3AddSub, 5'd12, 5'd0)));
    rows.push_back(exec_row(i_op(12'h7FF, rvalu_pkg::F3Slt, 5'd13, 5'd2)));
    rows.push_back(exec_row(i_op(12'hFFF, rvalu_pkg::F3Sltu, 5'd14, 5'd1)));
    rows.push_back(exec_row(i_op(12'h800, rvalu_pkg::F3Xor, 5'd15, 5'd31)));
    rows.push_back(exec_row(i_op(12'h555, rvalu_pkg::F3Or, 5'd16, 5'd0)));
    rows.push_back(exec_row(i_op(12'h800, rvalu_pkg::F3And, 5'd17, 5'd1)));
    rows.push_back(exec_row(i_op({rvalu_pkg::Funct7Zero, 5'd31}, rvalu_pkg::F3Sll, 5'd18,
                                 5'd1)));
    rows.push_back(exec_row(i_op({rvalu_pkg::Funct7Zero, 5'd1}, rvalu_pkg::F3Srl, 5'd19,
                                 5'd2)));
    rows.push_back(exec_row(i_op({rvalu_pkg::Funct7Alt, 5'd31}, rvalu_pkg::F3Srl, 5'd20,
                                 5'd2)));
    rows.push_back(known_row(rvalu_pkg::ModeExec,
                             r_op(rvalu_pkg::Funct7Alt, rvalu_pkg::F3Xor, 5'd21, 5'd1, 5'd2),
                             '0, '0, rvalu_pkg::StIllegal, 1'b0, 5'd21, '0));
    rows.push_back(known_row(rvalu_pkg::ModeExec,
                             i_op({rvalu_pkg::Funct7Alt, 5'd1}, rvalu_pkg::F3Sll, 5'd22, 5'd1),
                             '0, '0, rvalu_pkg::StIllegal, 1'b0, 5'd22, '0));
    rows.push_back(known_row(rvalu_pkg::ModeExec,
                             i_op({7'h7F, 5'd3}, rvalu_pkg::F3Srl, 5'd23, 5'd1),
                             '0, '0, rvalu_pkg::StIllegal, 1'b0, 5'd23, '0));
    rows.push_back(known_row(rvalu_pkg::ModeExec, {25'h1FF_FFFF, rvalu_pkg::OpcJal}, '0, '0,
                             rvalu_pkg::StUnimpl, 1'b0, 5'd31, '0));
    rows.push_back(known_row(rvalu_pkg::ModeExec, {20'h0, 5'd24, OpcUndef}, '0, '0,
                             rvalu_pkg::StNonexist, 1'b0, 5'd24, '0));
    rows.push_back(known_row(rvalu_pkg::ModeNop, '1, 5'd31, '1, rvalu_pkg::StOk, 1'b0,
                             5'd31, '0));

    send_idle_pct = 13;
    stall_pct     = 13;
    foreach (rows[i]) send_request(rows[i]);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      stall_pct     = stall_plan[ph];
      // hold the result side off while requests keep coming, so the input backs up
      if (ph == 0) holds_asked++;
      for (int n = 0; n < RandPerPhase; n++) begin
        kind = $urandom_range(99);
        rd   = rvalu_pkg::reg_addr_t'($urandom());
        rs1  = rvalu_pkg::reg_addr_t'($urandom());
        rs2  = rvalu_pkg::reg_addr_t'($urandom());
        f3   = 3'($urandom());
        it = exec_row($urandom());
        it.idx   = rvalu_pkg::reg_addr_t'($urandom());
        it.value = $urandom();
        if (kind < 15) begin
          it.mode = rvalu_pkg::ModeLoad;
          case ($urandom_range(5))
            0: it.value = '0;
            1: it.value = '1;
            2: it.value = 32'h8000_0000;
            3: it.value = 32'h7FFF_FFFF;
            4: it.value = 32'd1;
            default: ;
          endcase
        end else if (kind < 22) begin
          it.mode = rvalu_pkg::ModeRead;
        end else if (kind < 25) begin
          it.mode = rvalu_pkg::ModeNop;
        end else if (kind < 58) begin
          if ($urandom_range(9) == 0) f7 = 7'($urandom());
          else f7 = $urandom_range(1) ? rvalu_pkg::Funct7Alt : rvalu_pkg::Funct7Zero;
          it.instr = r_op(f7, f3, rd, rs1, rs2);
        end else if (kind < 92) begin
          imm = 12'($urandom());
          if ((f3 inside {rvalu_pkg::F3Sll, rvalu_pkg::F3Srl}) && $urandom_range(7) != 0)
            imm[11:5] = $urandom_range(1) ? rvalu_pkg::Funct7Alt : rvalu_pkg::Funct7Zero;
          it.instr = i_op(imm, f3, rd, rs1);
        end else if (kind < 96) begin
          it.instr[6:0] = unimpl_opcodes[4'($urandom_range(8))];
        end
        send_request(it);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
